>>> hdl/negacyclic_poly_mul_mod_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the negacyclic polynomial multiplier
// Shorthand for clocked assertions that are disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef NEGACYCLIC_POLY_MUL_MOD_MACROS_SVH
`define NEGACYCLIC_POLY_MUL_MOD_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NPMM_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NPMM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/npmm_pkg.sv
// ----------------------------------------------------------------------------
// npmm_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package npmm_pkg;

	localparam int MAX_DEGREE_DEF = 1024;
	localparam int COEF_BITS_DEF  = 62;

	localparam int MOD_W     = 63;
	localparam int DEG_W     = 11;
	localparam int REG_IDX_W = 1;

	localparam logic [MOD_W-1:0] MOD_RESET = {1'b1, {(MOD_W-1){1'b0}}};
	localparam logic [DEG_W-1:0] DEG_RESET = 11'd1024;

	localparam logic [REG_IDX_W-1:0] REG_MODULUS = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_DEGREE  = 1'b1;

	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_COMPUTE = 1'b1;

	typedef struct packed {
		logic take;
		logic rd;
		logic red_init;
		logic red_step;
		logic mul_init;
		logic mul_step;
		logic acc_step;
		logic finish;
	} npmm_cmd_t;

	typedef struct packed {
		logic op_compute;
		logic in_range;
		logic q_ok;
		logic bit_last;
		logic j_last;
		logic out_free;
	} npmm_sts_t;

endpackage

>>> hdl/npmm_ram.sv
// ----------------------------------------------------------------------------
// npmm_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module npmm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/npmm_ctrl.sv
// ----------------------------------------------------------------------------
// npmm_ctrl
// Sequencer that steps the datapath through loads, the per-pair modular
// reduce, multiply and accumulate, and the hand-off to the output register.
// ----------------------------------------------------------------------------
module npmm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  npmm_pkg::npmm_sts_t  sts,
	output npmm_pkg::npmm_cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_RED   = 3'd3;
	localparam logic [2:0] ST_MULI  = 3'd4;
	localparam logic [2:0] ST_MUL   = 3'd5;
	localparam logic [2:0] ST_ACC   = 3'd6;
	localparam logic [2:0] ST_DONE  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
				if (in_valid && sts.op_compute) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (!sts.in_range) begin
					state_d = ST_IDLE;
				end else if (!sts.q_ok) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd       = 1'b1;
				cmd.red_init = 1'b1;
				state_d      = ST_RED;
			end
			ST_RED: begin
				cmd.red_step = 1'b1;
				if (sts.bit_last) begin
					state_d = ST_MULI;
				end
			end
			ST_MULI: begin
				cmd.mul_init = 1'b1;
				state_d      = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul_step = 1'b1;
				if (sts.bit_last) begin
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				cmd.acc_step = 1'b1;
				state_d      = sts.j_last ? ST_DONE : ST_READ;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> hdl/npmm_dp.sv
// ----------------------------------------------------------------------------
// npmm_dp
// Operand stores, configuration registers, bit-serial modular reducer and
// multiplier, unsigned modular add/subtract accumulator and the result register.
// ----------------------------------------------------------------------------
module npmm_dp #(
	parameter int MAX_DEGREE = npmm_pkg::MAX_DEGREE_DEF,
	parameter int COEF_BITS  = npmm_pkg::COEF_BITS_DEF,
	localparam int IDX_W = $clog2(MAX_DEGREE),
	localparam int IN_W  = ((IDX_W + 2 * COEF_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((IDX_W + COEF_BITS + 7) / 8) * 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [IN_W-1:0]                     in_tdata,
	input  logic                                in_tuser,
	input  logic                                cfg_valid,
	input  logic [npmm_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [npmm_pkg::MOD_W-1:0]          cfg_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [OUT_W-1:0]                    out_tdata,
	input  npmm_pkg::npmm_cmd_t                 cmd,
	output npmm_pkg::npmm_sts_t                 sts
);

	localparam int MW    = npmm_pkg::MOD_W;
	localparam int DW    = npmm_pkg::DEG_W;
	localparam int NW    = IDX_W + 1;
	localparam int CW    = (DW > NW) ? DW : NW;
	localparam int BIT_W = $clog2(COEF_BITS);

	// Brings s < 3q back into [0, q).
	function automatic logic [MW-1:0] fold3(input logic [MW+1:0] s, input logic [MW-1:0] q);
		logic [MW+2:0] d1;
		logic [MW+2:0] d2;
		d1 = {1'b0, s} - {3'b000, q};
		d2 = {1'b0, s} - {2'b00, q, 1'b0};
		if (!d2[MW+2]) begin
			fold3 = d2[MW-1:0];
		end else if (!d1[MW+2]) begin
			fold3 = d1[MW-1:0];
		end else begin
			fold3 = s[MW-1:0];
		end
	endfunction

	logic [MW-1:0]        q_q;
	logic [DW-1:0]        deg_q;
	logic [IDX_W-1:0]     idx_q;
	logic [IDX_W-1:0]     j_q;
	logic [BIT_W-1:0]     bit_q;
	logic [MW-1:0]        r_q;
	logic [MW-1:0]        ared_q;
	logic [MW-1:0]        acc_q;
	logic                 out_valid_q;
	logic [IDX_W-1:0]     out_idx_q;
	logic [COEF_BITS-1:0] out_coef_q;

	logic [IDX_W-1:0]     in_idx;
	logic [COEF_BITS-1:0] in_a;
	logic [COEF_BITS-1:0] in_b;
	logic [COEF_BITS-1:0] a_dout;
	logic [COEF_BITS-1:0] b_dout;
	logic                 we;
	logic [CW-1:0]        deg_x;
	logic [CW-1:0]        n_x;
	logic [NW-1:0]        n_c;
	logic [NW-1:0]        b_off;
	logic [IDX_W-1:0]     b_addr;
	logic                 wrapped;
	logic [MW+1:0]        red_sum;
	logic [MW+1:0]        mul_sum;
	logic [MW:0]          add_sum;
	logic [MW+1:0]        add_cmp;
	logic [MW-1:0]        acc_add;
	logic [MW:0]          sub_dif;
	logic [MW-1:0]        acc_sub;

	assign in_idx = in_tdata[IDX_W-1:0];
	assign in_a   = in_tdata[IDX_W +: COEF_BITS];
	assign in_b   = in_tdata[IDX_W + COEF_BITS +: COEF_BITS];

	assign we = cmd.take && (in_tuser == npmm_pkg::OP_LOAD)
		&& ({1'b0, in_idx} < NW'(MAX_DEGREE));

	// Effective ring degree, clamped to [1, MAX_DEGREE].
	assign deg_x = CW'(deg_q);
	always_comb begin
		if (deg_x == '0) begin
			n_x = CW'(1);
		end else if (deg_x > CW'(MAX_DEGREE)) begin
			n_x = CW'(MAX_DEGREE);
		end else begin
			n_x = deg_x;
		end
	end
	assign n_c = n_x[NW-1:0];

	// Partner index of b, wrapping around the ring for j above the target.
	assign wrapped = j_q > idx_q;
	always_comb begin
		b_off = {1'b0, idx_q} - {1'b0, j_q};
		if (wrapped) begin
			b_off = b_off + n_c;
		end
	end
	assign b_addr = b_off[IDX_W-1:0];

	npmm_ram #(.WIDTH(COEF_BITS), .DEPTH(MAX_DEGREE)) u_a_ram (
		.clk   (clk),
		.we    (we),
		.waddr (in_idx),
		.wdata (in_a),
		.re    (cmd.rd),
		.raddr (j_q),
		.rdata (a_dout)
	);

	npmm_ram #(.WIDTH(COEF_BITS), .DEPTH(MAX_DEGREE)) u_b_ram (
		.clk   (clk),
		.we    (we),
		.waddr (in_idx),
		.wdata (in_b),
		.re    (cmd.rd),
		.raddr (b_addr),
		.rdata (b_dout)
	);

	// One Horner step per cycle: reduce a, then multiply by b one bit at a time.
	assign red_sum = {1'b0, r_q, a_dout[bit_q]};
	assign mul_sum = {1'b0, r_q, 1'b0} + {2'b00, (b_dout[bit_q] ? ared_q : '0)};

	assign add_sum = {1'b0, acc_q} + {1'b0, r_q};
	assign add_cmp = {1'b0, add_sum} - {2'b00, q_q};
	assign acc_add = add_cmp[MW+1] ? add_sum[MW-1:0] : add_cmp[MW-1:0];
	assign sub_dif = {1'b0, acc_q} - {1'b0, r_q};
	assign acc_sub = sub_dif[MW] ? (sub_dif[MW-1:0] + q_q) : sub_dif[MW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q   <= npmm_pkg::MOD_RESET;
			deg_q <= npmm_pkg::DEG_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				npmm_pkg::REG_MODULUS: q_q   <= cfg_data;
				npmm_pkg::REG_DEGREE:  deg_q <= cfg_data[DW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && (in_tuser == npmm_pkg::OP_COMPUTE)) begin
			idx_q <= in_idx;
			j_q   <= '0;
			acc_q <= '0;
		end
		if (cmd.red_init) begin
			r_q   <= '0;
			bit_q <= BIT_W'(COEF_BITS - 1);
		end
		if (cmd.red_step) begin
			r_q   <= fold3(red_sum, q_q);
			bit_q <= bit_q - BIT_W'(1);
		end
		if (cmd.mul_init) begin
			ared_q <= r_q;
			r_q    <= '0;
			bit_q  <= BIT_W'(COEF_BITS - 1);
		end
		if (cmd.mul_step) begin
			r_q   <= fold3(mul_sum, q_q);
			bit_q <= bit_q - BIT_W'(1);
		end
		if (cmd.acc_step) begin
			acc_q <= wrapped ? acc_sub : acc_add;
			j_q   <= j_q + IDX_W'(1);
		end
		if (cmd.finish) begin
			out_idx_q  <= idx_q;
			out_coef_q <= acc_q[COEF_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= cmd.finish || (out_valid_q && !out_ready);
		end
	end

	assign out_valid = out_valid_q;
	assign out_tdata = OUT_W'({out_coef_q, out_idx_q});

	assign sts.op_compute = (in_tuser == npmm_pkg::OP_COMPUTE);
	assign sts.in_range   = {1'b0, idx_q} < n_c;
	assign sts.q_ok       = (q_q[MW-1:1] != '0);
	assign sts.bit_last   = (bit_q == '0);
	assign sts.j_last     = ({1'b0, j_q} == (n_c - NW'(1)));
	assign sts.out_free   = !out_valid_q || out_ready;

endmodule

>>> hdl/negacyclic_poly_mul_mod.sv
// ----------------------------------------------------------------------------
// negacyclic_poly_mul_mod
// Schoolbook multiplier of two polynomials modulo X^n + 1 with coefficients
// modulo q. Loads fill the operand stores; each compute with an index below n
// returns one product coefficient reduced into [0, q).
//
//   Channel  Direction  Handshake          Contents
//   s_*      in         s_tvalid/s_tready  tuser: op; tdata: index, a, b
//   m_*      out        m_tvalid/m_tready  tdata: result_index, product_coef
//   cfg_*    in         cfg_valid/ready    cfg_index, cfg_data
//
// A load transfer is taken whenever the block is idle. A compute holds the input
// while the bit-serial modular unit works through each pair: it reduces a_j one
// bit at a time, then multiplies by b one bit at a time, then accumulates.
// Reset is asynchronous; the operand stores are undefined until loaded.
// A finished result waits in the output register while the next transfer is
// taken; a compute that ends while that register is still full waits for it.
// ----------------------------------------------------------------------------
`include "negacyclic_poly_mul_mod_macros.svh"

module negacyclic_poly_mul_mod #(
	parameter int MAX_DEGREE = npmm_pkg::MAX_DEGREE_DEF,
	parameter int COEF_BITS  = npmm_pkg::COEF_BITS_DEF,
	localparam int IDX_W = $clog2(MAX_DEGREE),
	localparam int IN_W  = ((IDX_W + 2 * COEF_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((IDX_W + COEF_BITS + 7) / 8) * 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [IN_W-1:0]                s_tdata,   // index, a_value, b_value, zero pad
	input  logic                           s_tuser,   // op
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [OUT_W-1:0]               m_tdata,   // result_index, product_coef, zero pad
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [npmm_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [npmm_pkg::MOD_W-1:0]     cfg_data
);

	npmm_pkg::npmm_cmd_t cmd;
	npmm_pkg::npmm_sts_t sts;

	assign cfg_ready = 1'b1;

	npmm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	npmm_dp #(.MAX_DEGREE(MAX_DEGREE), .COEF_BITS(COEF_BITS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_tdata  (s_tdata),
		.in_tuser  (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_tdata (m_tdata),
		.cmd       (cmd),
		.sts       (sts)
	);

	`NPMM_ASSERT_NEXT(a_busy_after_compute, s_tvalid && s_tready && (s_tuser == npmm_pkg::OP_COMPUTE), !s_tready, "input taken while a compute is running")
	`NPMM_ASSERT_SAME(a_no_overwrite, cmd.finish, !m_tvalid || m_tready, "result register overwritten before transfer")
	`NPMM_ASSERT_SAME(a_valid_from_finish, $rose(m_tvalid), $past(cmd.finish), "result valid without a finished compute")

endmodule
